[src/round_robin_timed_task_scheduler_macros.svh]
// Assertion helpers for the scheduler, clocked on clk and held off during reset.
`ifndef ROUND_ROBIN_TIMED_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TIMED_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication.
`define RRTS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: scheduler check failed");

// Plain invariant.
`define RRTS_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("%m: scheduler invariant failed");

`endif

[src/rrts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rrts_pkg;

	localparam int TASK_SLOTS = 10;
	localparam int SLOT_W     = 4;
	localparam int NOW_W      = 32;
	localparam int TID_W      = 16;
	localparam int DUR_W      = 31;
	localparam int WAIT_W     = 16;
	localparam int OP_W       = 3;
	localparam int ST_W       = 2;

	localparam logic [SLOT_W:0]   SLOTS_N   = (SLOT_W + 1)'(TASK_SLOTS);
	localparam logic [WAIT_W-1:0] CAP_RESET = WAIT_W'(500);

	typedef logic [SLOT_W-1:0] slot_t;

	typedef enum logic [OP_W-1:0] {
		OP_START  = 3'd0,
		OP_STOP   = 3'd1,
		OP_RUN    = 3'd2,
		OP_SNOOZE = 3'd3,
		OP_DONE   = 3'd4
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 2'd0,
		ST_IGNORED = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEED,
		S_SCAN,
		S_DONE
	} fsm_t;

	typedef enum logic [1:0] {
		UK_FILL,
		UK_FREE,
		UK_PERIOD,
		UK_REARM
	} upd_kind_t;

	// Item context broadcast to every cell while a probe walks the chain.
	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [NOW_W-1:0] now;
		slot_t            sidx;
		slot_t            cursor;
		logic             running;
	} ctx_t;

	// Word handed from cell to cell.
	typedef struct packed {
		logic               free_found;
		slot_t              free_idx;
		logic               aft_found;
		slot_t              aft_idx;
		logic [TID_W-1:0]   aft_task;
		logic               any_found;
		slot_t              any_idx;
		logic [TID_W-1:0]   any_task;
		logic signed [NOW_W-1:0] min_d;
	} probe_t;

	// Slot update issued at commit.
	typedef struct packed {
		logic             en;
		slot_t            slot;
		upd_kind_t        kind;
		logic [TID_W-1:0] task_id;
		logic [DUR_W-1:0] period;
		logic [NOW_W-1:0] wake;
	} upd_t;

endpackage
`default_nettype wire

[src/rrts_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface rrts_in_if;
	import rrts_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [NOW_W-1:0]  now_ms;
	logic [TID_W-1:0]  task_id;
	logic [DUR_W-1:0]  duration_ms;
	logic [SLOT_W-1:0] slot_index;

	modport source (output valid, opcode, now_ms, task_id, duration_ms, slot_index,
		input ready);
	modport sink (input valid, opcode, now_ms, task_id, duration_ms, slot_index,
		output ready);
endinterface

interface rrts_out_if;
	import rrts_pkg::*;

	logic              valid;
	logic              ready;
	logic [ST_W-1:0]   status;
	logic [SLOT_W-1:0] chosen_slot;
	logic [TID_W-1:0]  chosen_task_id;
	logic [WAIT_W-1:0] wait_ms;

	modport source (output valid, status, chosen_slot, chosen_task_id, wait_ms,
		input ready);
	modport sink (input valid, status, chosen_slot, chosen_task_id, wait_ms,
		output ready);
endinterface
`default_nettype wire

[src/round_robin_timed_task_scheduler.sv]
`timescale 1ns / 1ps
`default_nettype none
// Round-robin timed task scheduler. Each request word carries an opcode (start, stop,
// run next, snooze, done) and the current wrapping millisecond time; each request
// returns exactly one response word with a status, the slot and task id started or
// chosen, and the wait until the earliest wake, capped by idle_wait_cap (written
// through cfg_we/cfg_wdata, reset value 500; the user must write it only while idle, as
// the block itself does not enforce that). The task table is a row of TASK_SLOTS cells.
// Once a request is accepted it seeds a probe word, which walks the chain cell by cell
// collecting the first free slot, the round-robin run candidate and the minimum wait;
// then the response is committed. The next request is taken while a finished response
// still waits in the output register; a busy output only delays the commit. The table
// needs no clearing pass after reset.
module round_robin_timed_task_scheduler (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	rrts_in_if.sink                    req,
	rrts_out_if.source                 rsp,
	input  wire logic                  cfg_we,
	input  wire logic [rrts_pkg::WAIT_W-1:0] cfg_wdata
);
	import rrts_pkg::*;

	fsm_t              state_q, state_d;
	logic [WAIT_W-1:0] cap_q;
	slot_t             cursor_q, cursor_d;
	logic              running_q, running_d;

	// request held for the whole walk
	logic [OP_W-1:0]   op_q;
	logic [NOW_W-1:0]  now_q;
	logic [TID_W-1:0]  tid_q;
	logic [DUR_W-1:0]  dur_q;
	slot_t             sidx_q;

	// response word register
	logic              rsp_valid_q;
	status_t           status_q, status_d;
	slot_t             cslot_q, cslot_d;
	logic [TID_W-1:0]  ctask_q, ctask_d;
	logic [WAIT_W-1:0] wait_q, wait_d;

	logic              accept;
	logic              fire;
	ctx_t              ctx;
	upd_t              upd_d;
	upd_t              upd;
	probe_t            seed;
	probe_t            chain [TASK_SLOTS+1];
	logic [TASK_SLOTS:0] chain_vld;
	probe_t            tail;

	logic signed [NOW_W-1:0] best;
	logic signed [NOW_W-1:0] dur_s;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);

	// Broadcast context: cursor and running stay put until the commit.
	assign ctx.op      = op_q;
	assign ctx.now     = now_q;
	assign ctx.sidx    = sidx_q;
	assign ctx.cursor  = cursor_q;
	assign ctx.running = running_q;

	// Seed the probe: nothing found yet, minimum starts at the cap.
	always_comb begin
		seed       = '0;
		seed.min_d = signed'({{(NOW_W - WAIT_W){1'b0}}, cap_q});
	end

	assign chain[0]     = seed;
	assign chain_vld[0] = (state_q == S_SEED);

	for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
		rrts_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cell_idx     (SLOT_W'(i)),
			.ctx          (ctx),
			.upd          (upd),
			.probe_vld_in (chain_vld[i]),
			.probe_in     (chain[i]),
			.probe_vld_out(chain_vld[i+1]),
			.probe_out    (chain[i+1])
		);
	end

	// The tail cell holds its word until the next probe, so the commit may stall.
	assign tail = chain[TASK_SLOTS];

	// Sequencer: seed, walk, then commit once the output register is free.
	always_comb begin
		state_d = state_q;
		fire    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_SEED;
				end
			end
			S_SEED: begin
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (chain_vld[TASK_SLOTS]) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					fire    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Decode the walked probe into the slot update and the response word.
	always_comb begin
		upd_d     = '0;
		status_d  = ST_IGNORED;
		cslot_d   = '0;
		ctask_d   = '0;
		cursor_d  = cursor_q;
		running_d = running_q;
		case (op_q)
			OP_START: begin
				if (tail.free_found) begin
					upd_d.en      = 1'b1;
					upd_d.slot    = tail.free_idx;
					upd_d.kind    = UK_FILL;
					upd_d.task_id = tid_q;
					upd_d.period  = dur_q;
					upd_d.wake    = now_q + {1'b0, dur_q};
					status_d      = ST_OK;
					cslot_d       = tail.free_idx;
					ctask_d       = tid_q;
				end else begin
					status_d = ST_FULL;
				end
			end
			OP_STOP: begin
				if ({1'b0, sidx_q} < SLOTS_N) begin
					upd_d.en   = 1'b1;
					upd_d.slot = sidx_q;
					upd_d.kind = UK_FREE;
					status_d   = ST_OK;
					// stopping the running slot drops the running mark
					if (running_q && (sidx_q == cursor_q)) begin
						running_d = 1'b0;
					end
				end
			end
			OP_RUN: begin
				// prefer the first eligible slot past the cursor, else wrap around
				if (!running_q && tail.aft_found) begin
					cursor_d  = tail.aft_idx;
					running_d = 1'b1;
					status_d  = ST_OK;
					cslot_d   = tail.aft_idx;
					ctask_d   = tail.aft_task;
				end else if (!running_q && tail.any_found) begin
					cursor_d  = tail.any_idx;
					running_d = 1'b1;
					status_d  = ST_OK;
					cslot_d   = tail.any_idx;
					ctask_d   = tail.any_task;
				end
			end
			OP_SNOOZE: begin
				if (running_q && ({1'b0, cursor_q} < SLOTS_N)) begin
					upd_d.en     = 1'b1;
					upd_d.slot   = cursor_q;
					upd_d.kind   = UK_PERIOD;
					upd_d.period = dur_q;
					status_d     = ST_OK;
				end
			end
			OP_DONE: begin
				if (running_q && ({1'b0, cursor_q} < SLOTS_N)) begin
					upd_d.en   = 1'b1;
					upd_d.slot = cursor_q;
					upd_d.kind = UK_REARM;
					running_d  = 1'b0;
					status_d   = ST_OK;
				end
			end
			default: begin
			end
		endcase
	end

	// Wait after the operation: a freshly started slot wakes one period out.
	always_comb begin
		dur_s = signed'({1'b0, dur_q});
		best  = tail.min_d;
		if ((op_q == OP_START) && tail.free_found && (dur_s < best)) begin
			best = dur_s;
		end
		wait_d = best[NOW_W-1] ? '0 : best[WAIT_W-1:0];
	end

	// Apply the update to the cells only in the commit cycle.
	always_comb begin
		upd    = upd_d;
		upd.en = upd_d.en && fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= CAP_RESET;
			cursor_q    <= '0;
			running_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (fire) begin
				cursor_q    <= cursor_d;
				running_q   <= running_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.opcode;
			now_q  <= req.now_ms;
			tid_q  <= req.task_id;
			dur_q  <= req.duration_ms;
			sidx_q <= req.slot_index;
		end
		if (fire) begin
			status_q <= status_d;
			cslot_q  <= cslot_d;
			ctask_q  <= ctask_d;
			wait_q   <= wait_d;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = status_q;
	assign rsp.chosen_slot    = cslot_q;
	assign rsp.chosen_task_id = ctask_q;
	assign rsp.wait_ms        = wait_q;

`include "round_robin_timed_task_scheduler_macros.svh"

	// only one probe word is ever in flight along the chain
	`RRTS_ASSERT_ALWAYS(a_one_probe, $onehot0(chain_vld))
	// the probe reaches the tail only while the sequencer is waiting for it
	`RRTS_ASSERT_IMP(a_tail_in_scan, chain_vld[TASK_SLOTS], state_q == S_SCAN)
	// a running task always points at a real slot
	`RRTS_ASSERT_IMP(a_cursor_range, running_q, {1'b0, cursor_q} < SLOTS_N)

endmodule
`default_nettype wire

[src/rrts_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module rrts_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire rrts_pkg::slot_t cell_idx,
	input  wire rrts_pkg::ctx_t  ctx,
	input  wire rrts_pkg::upd_t  upd,
	input  wire logic            probe_vld_in,
	input  wire rrts_pkg::probe_t probe_in,
	output logic                 probe_vld_out,
	output rrts_pkg::probe_t     probe_out
);
	import rrts_pkg::*;

	logic             valid_q;
	logic [TID_W-1:0] task_q;
	logic [DUR_W-1:0] period_q;
	logic [NOW_W-1:0] wake_q;
	logic             vld_q;
	probe_t           probe_q;

	logic [NOW_W-1:0]        ahead;
	logic [NOW_W-1:0]        late;
	logic signed [NOW_W-1:0] cand;
	logic                    eligible;
	logic                    contrib;
	logic                    use_period;
	logic                    hit;
	probe_t                  nxt;

	assign hit = upd.en && (upd.slot == cell_idx);

	always_comb begin
		ahead      = wake_q - ctx.now;
		late       = ctx.now - wake_q;
		eligible   = valid_q && !late[NOW_W-1];
		// a slot being stopped no longer counts toward the wait
		contrib    = valid_q && !((ctx.op == OP_STOP) && (ctx.sidx == cell_idx));
		// the slot being rearmed will wake one period from now
		use_period = (ctx.op == OP_DONE) && ctx.running && (ctx.cursor == cell_idx);
		cand       = use_period ? signed'({1'b0, period_q}) : signed'(ahead);
		nxt        = probe_in;
		if (!valid_q && !probe_in.free_found) begin
			nxt.free_found = 1'b1;
			nxt.free_idx   = cell_idx;
		end
		if (eligible && (cell_idx > ctx.cursor) && !probe_in.aft_found) begin
			nxt.aft_found = 1'b1;
			nxt.aft_idx   = cell_idx;
			nxt.aft_task  = task_q;
		end
		if (eligible && !probe_in.any_found) begin
			nxt.any_found = 1'b1;
			nxt.any_idx   = cell_idx;
			nxt.any_task  = task_q;
		end
		if (contrib && (cand < probe_in.min_d)) begin
			nxt.min_d = cand;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			vld_q   <= 1'b0;
		end else begin
			vld_q <= probe_vld_in;
			if (hit && (upd.kind == UK_FILL)) begin
				valid_q <= 1'b1;
			end else if (hit && (upd.kind == UK_FREE)) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (probe_vld_in) begin
			probe_q <= nxt;
		end
		if (hit) begin
			case (upd.kind)
				UK_FILL: begin
					task_q   <= upd.task_id;
					period_q <= upd.period;
					wake_q   <= upd.wake;
				end
				UK_PERIOD: begin
					period_q <= upd.period;
				end
				UK_REARM: begin
					wake_q <= ctx.now + {1'b0, period_q};
				end
				default: begin
				end
			endcase
		end
	end

	assign probe_vld_out = vld_q;
	assign probe_out     = probe_q;
endmodule
`default_nettype wire

[tb/rrts_reply_check.sv]
`timescale 1ns / 1ps
// Watches both channels of the scheduler, keeps a shadow task table and
// compares every response word against the predicted one.
module rrts_reply_check (
	input  logic                        clk,
	input  logic                        arst_n,
	rrts_in_if                          req,
	rrts_out_if                         rsp,
	input  logic                        cfg_we,
	input  logic [rrts_pkg::WAIT_W-1:0] cfg_wdata,
	output int                          fail_count,
	output int                          open_count
);
	import rrts_pkg::*;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		slot_t             slot;
		logic [TID_W-1:0]  task_id;
		logic [WAIT_W-1:0] wait_ms;
	} reply_t;

	logic              tbl_used   [TASK_SLOTS];
	logic [TID_W-1:0]  tbl_task   [TASK_SLOTS];
	logic [NOW_W-1:0]  tbl_period [TASK_SLOTS];
	logic [NOW_W-1:0]  tbl_wake   [TASK_SLOTS];
	slot_t             rr_cursor;
	logic              busy;
	logic [WAIT_W-1:0] wait_cap;
	reply_t            expected_replies[$];

	initial fail_count = 0;

	function automatic logic signed [NOW_W-1:0] wrap_diff(input logic [NOW_W-1:0] a,
		input logic [NOW_W-1:0] b);
		return $signed(a - b);
	endfunction

	// Apply one request word to the shadow table and return the response it earns.
	function automatic reply_t schedule_step(input logic [OP_W-1:0] op,
		input logic [NOW_W-1:0] now, input logic [TID_W-1:0] tid,
		input logic [DUR_W-1:0] dur, input slot_t sidx);
		reply_t r;
		int     s;
		bit     hit;
		longint best;
		longint d;
		r        = '0;
		r.status = ST_IGNORED;
		hit      = 1'b0;
		case (op)
			OP_START: begin
				r.status = ST_FULL;
				for (s = 0; s < TASK_SLOTS; s++) begin
					if (!hit && !tbl_used[s]) begin
						hit           = 1'b1;
						tbl_used[s]   = 1'b1;
						tbl_task[s]   = tid;
						tbl_period[s] = NOW_W'(dur);
						tbl_wake[s]   = now + NOW_W'(dur);
						r.status      = ST_OK;
						r.slot        = slot_t'(s);
						r.task_id     = tid;
					end
				end
			end
			OP_STOP: begin
				if (sidx < TASK_SLOTS) begin
					tbl_used[sidx] = 1'b0;
					// freeing the running slot also ends the run
					if (busy && sidx == rr_cursor)
						busy = 1'b0;
					r.status = ST_OK;
				end
			end
			OP_RUN: begin
				if (!busy) begin
					s = int'(rr_cursor);
					for (int i = 0; i < TASK_SLOTS; i++) begin
						if (!hit) begin
							s = (s + 1 >= TASK_SLOTS) ? 0 : s + 1;
							if (tbl_used[s] && wrap_diff(now, tbl_wake[s]) >= 0) begin
								hit       = 1'b1;
								rr_cursor = slot_t'(s);
								busy      = 1'b1;
								r.status  = ST_OK;
								r.slot    = slot_t'(s);
								r.task_id = tbl_task[s];
							end
						end
					end
				end
			end
			OP_SNOOZE: begin
				if (busy) begin
					tbl_period[rr_cursor] = NOW_W'(dur);
					r.status = ST_OK;
				end
			end
			OP_DONE: begin
				if (busy) begin
					tbl_wake[rr_cursor] = now + tbl_period[rr_cursor];
					busy     = 1'b0;
					r.status = ST_OK;
				end
			end
			default: ;
		endcase
		best = longint'(wait_cap);
		for (s = 0; s < TASK_SLOTS; s++) begin
			if (tbl_used[s]) begin
				d = wrap_diff(tbl_wake[s], now);
				if (d < best)
					best = d;
			end
		end
		if (best < 0)
			best = 0;
		r.wait_ms = best[WAIT_W-1:0];
		return r;
	endfunction

	task automatic flag_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		reply_t got;
		if (!arst_n) begin
			for (int s = 0; s < TASK_SLOTS; s++)
				tbl_used[s] = 1'b0;
			rr_cursor = '0;
			busy      = 1'b0;
			wait_cap  = CAP_RESET;
			expected_replies.delete();
		end else begin
			if (cfg_we)
				wait_cap = cfg_wdata;
			// check the outgoing word before queuing one for a new request
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.status, rsp.chosen_slot, rsp.chosen_task_id, rsp.wait_ms};
				if (expected_replies.size() == 0) begin
					$display("%0t: unexpected response: status %0d slot %0d task %0d wait %0d",
						$time, got.status, got.slot, got.task_id, got.wait_ms);
					fail_count++;
				end else begin
					want = expected_replies.pop_front();
					flag_field("status", want.status, got.status);
					flag_field("chosen_slot", want.slot, got.slot);
					flag_field("chosen_task_id", want.task_id, got.task_id);
					flag_field("wait_ms", want.wait_ms, got.wait_ms);
				end
			end
			if (req.valid && req.ready)
				expected_replies.push_back(schedule_step(req.opcode, req.now_ms,
					req.task_id, req.duration_ms, req.slot_index));
		end
		open_count = expected_replies.size();
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for the round-robin task scheduler. The checker beside
// the block predicts every response word; this module only makes traffic.
module testbench;
	import rrts_pkg::*;

	// opcodes the block does not know; it must answer them as ignored
	localparam logic [OP_W-1:0] OP_BAD_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_BAD_LAST  = 3'd7;

	// give a word room to pass through the block before a register write
	localparam int SETTLE_CYCLES  = 20;
	localparam int DRAIN_CYCLES   = 40;
	// must exceed the longest honest stretch without a handshake
	localparam int WATCHDOG_LIMIT = 3000;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we;
	logic [WAIT_W-1:0] cfg_wdata;
	int                fail_count;
	int                open_count;
	int                stuck_cycles = 0;
	int                src_quiet_left = 0;
	bit                calm = 1'b0;
	logic [NOW_W-1:0]  clock_ms;

	rrts_in_if  req();
	rrts_out_if rsp();

	round_robin_timed_task_scheduler i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	rrts_reply_check i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.open_count (open_count)
	);

	always #1 clk = ~clk;

	// Stall the response side in bursts; hold ready high in quiet stretches
	// and for the whole final phase.
	initial begin
		int stall_left;
		int quiet_left;
		rsp.ready  = 1'b0;
		stall_left = 0;
		quiet_left = 0;
		forever begin
			@(negedge clk);
			if (calm || quiet_left > 0) begin
				if (quiet_left > 0)
					quiet_left--;
				rsp.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else if ($urandom_range(0, 149) == 0) begin
				quiet_left = $urandom_range(60, 250);
				rsp.ready <= 1'b1;
			end else if ($urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 18) - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Drop the run if neither channel moves a word for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Present one request word, maybe after a gap, and hold it until taken.
	// Returns on the falling edge after acceptance with valid still high.
	task automatic send_request(input logic [OP_W-1:0] op, input logic [NOW_W-1:0] now,
		input logic [TID_W-1:0] tid, input logic [DUR_W-1:0] dur, input slot_t sidx);
		if (!calm) begin
			if (src_quiet_left > 0) begin
				src_quiet_left--;
			end else if ($urandom_range(0, 79) == 0) begin
				src_quiet_left = $urandom_range(20, 120);
			end else if ($urandom_range(0, 4) == 0) begin
				req.valid <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end
		end
		req.valid       <= 1'b1;
		req.opcode      <= op;
		req.now_ms      <= now;
		req.task_id     <= tid;
		req.duration_ms <= dur;
		req.slot_index  <= sidx;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	// Write the wait cap only once every response is back and the block has gone quiet.
	task automatic set_idle_cap(input logic [WAIT_W-1:0] cap);
		req.valid <= 1'b0;
		while (open_count != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Mostly run / snooze / done cycles on a table that fills and drains,
	// with starts, stops, stray snoozes and unknown opcodes mixed in.
	task automatic random_phase(input int count);
		int               sent;
		int               pick;
		logic [DUR_W-1:0] dur;
		sent = 0;
		while (sent < count) begin
			// advance the millisecond clock, now and then jump anywhere
			if ($urandom_range(0, 49) == 0)
				clock_ms = $urandom();
			else
				clock_ms += $urandom_range(0, 40);
			pick = $urandom_range(0, 99);
			if (pick < 80)
				dur = DUR_W'($urandom_range(0, 200));
			else if (pick < 95)
				dur = DUR_W'($urandom_range(0, 70000));
			else
				dur = DUR_W'($urandom());
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_request(OP_RUN, clock_ms, TID_W'($urandom_range(0, 65534)), dur,
					SLOT_W'($urandom_range(0, 15)));
				sent++;
				if ($urandom_range(0, 1) == 0) begin
					clock_ms += $urandom_range(0, 10);
					send_request(OP_SNOOZE, clock_ms, TID_W'($urandom_range(0, 65534)), dur,
						SLOT_W'($urandom_range(0, 15)));
					sent++;
				end
				if ($urandom_range(0, 9) < 7) begin
					clock_ms += $urandom_range(0, 30);
					send_request(OP_DONE, clock_ms, TID_W'($urandom_range(0, 65534)), dur,
						SLOT_W'($urandom_range(0, 15)));
					sent++;
				end
			end else if (pick < 70) begin
				send_request(OP_START, clock_ms, TID_W'($urandom_range(0, 65534)), dur,
					SLOT_W'($urandom_range(0, 15)));
				sent++;
			end else if (pick < 86) begin
				send_request(OP_STOP, clock_ms, TID_W'($urandom_range(0, 65534)), dur,
					SLOT_W'($urandom_range(0, 15)));
				sent++;
			end else if (pick < 95) begin
				send_request(($urandom_range(0, 1) == 0) ? OP_SNOOZE : OP_DONE, clock_ms,
					TID_W'($urandom_range(0, 65534)), dur, SLOT_W'($urandom_range(0, 15)));
				sent++;
			end else begin
				send_request(OP_W'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST)), clock_ms,
					TID_W'($urandom_range(0, 65534)), dur, SLOT_W'($urandom_range(0, 15)));
				sent++;
			end
		end
	endtask

	initial begin
		logic [DUR_W-1:0] first_periods [TASK_SLOTS];
		logic [NOW_W-1:0] base;
		logic [TID_W-1:0] tid;
		req.valid       = 1'b0;
		req.opcode      = OP_START;
		req.now_ms      = '0;
		req.task_id     = '0;
		req.duration_ms = '0;
		req.slot_index  = '0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		first_periods   = '{31'd0, 31'd1, 31'h7FFF_FFFF, 31'd20, 31'd100, 31'h1_0000,
			31'd499, 31'd500, 31'd65535, 31'd7};
		base            = 32'hFFFF_FFF0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty table: run, snooze and done have nothing to act on.
		send_request(OP_RUN, 32'h0, 16'h0, 31'h0, 4'd0);
		send_request(OP_SNOOZE, 32'hFFFF_FFFF, 16'hFFFE, 31'h7FFF_FFFF, 4'd15);
		send_request(OP_DONE, 32'h1234_5678, 16'h5A5A, 31'h2AAA_AAAA, 4'd5);
		// unknown opcodes, stops beyond the table and a stop of the empty last slot
		send_request(OP_BAD_FIRST, 32'h8000_0000, 16'h1, 31'd1, 4'd1);
		send_request(OP_BAD_LAST, 32'h7FFF_FFFF, 16'h7FFF, 31'd9, 4'd3);
		send_request(OP_STOP, 32'h10, 16'h0, 31'd0, 4'd15);
		send_request(OP_STOP, 32'h11, 16'h0, 31'd0, 4'd10);
		send_request(OP_STOP, 32'h12, 16'h0, 31'd0, 4'd9);

		// Fill every slot just below the wrap of the clock, then one too many.
		for (int s = 0; s < TASK_SLOTS; s++) begin
			tid = (s == 0) ? 16'h0 : (s == 1) ? 16'hFFFE : TID_W'($urandom_range(0, 65534));
			send_request(OP_START, base, tid, first_periods[s], slot_t'(s));
		end
		send_request(OP_START, base, 16'h4321, 31'd3, 4'd0);

		// Run across the wrap: the scan starts past the cursor, so slot 1 wins.
		// Refuse a second run, snooze, finish.
		send_request(OP_RUN, base + 32'd20, 16'h0, 31'd0, 4'd0);
		send_request(OP_RUN, base + 32'd20, 16'h0, 31'd0, 4'd0);
		send_request(OP_SNOOZE, base + 32'd20, 16'h0, 31'd5, 4'd0);
		send_request(OP_DONE, base + 32'd21, 16'h0, 31'd0, 4'd0);
		// next pick skips the far-off slot 2 and lands on slot 3; stopping it ends the run
		send_request(OP_RUN, base + 32'd30, 16'h0, 31'd0, 4'd0);
		send_request(OP_STOP, base + 32'd31, 16'h0, 31'd0, 4'd3);

		clock_ms = base + 32'd40;
		set_idle_cap(16'd0);
		random_phase(350);
		set_idle_cap(16'hFFFF);
		random_phase(350);
		set_idle_cap(WAIT_W'($urandom_range(1, 65534)));
		random_phase(350);
		set_idle_cap(WAIT_W'($urandom_range(200, 2000)));
		// no idling on either side from here on
		calm = 1'b1;
		random_phase(550);

		req.valid <= 1'b0;
		while (open_count != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
